/* hw/rtl/hrhp_pkg.sv */
`timescale 1ns / 1ps

package hrhp_pkg;

    // Default limits
    localparam int HRHP_MAX_FIELDS   = 64;
    localparam int HRHP_HEADER_BYTES = 1024;

    // Parser phases, one-hot
    typedef enum logic [9:0] {
        PH_METHOD  = 10'b00_0000_0001,
        PH_URI     = 10'b00_0000_0010,
        PH_VPREFIX = 10'b00_0000_0100,
        PH_VDIGITS = 10'b00_0000_1000,
        PH_VEND    = 10'b00_0001_0000,
        PH_NAME    = 10'b00_0010_0000,
        PH_VLEAD   = 10'b00_0100_0000,
        PH_VALUE   = 10'b00_1000_0000,
        PH_DONE    = 10'b01_0000_0000,
        PH_ERROR   = 10'b10_0000_0000
    } t_phase;

    // Byte roles
    localparam logic [2:0] ROLE_NONE    = 3'd0;
    localparam logic [2:0] ROLE_METHOD  = 3'd1;
    localparam logic [2:0] ROLE_URI     = 3'd2;
    localparam logic [2:0] ROLE_VERSION = 3'd3;
    localparam logic [2:0] ROLE_NAME    = 3'd4;
    localparam logic [2:0] ROLE_VALUE   = 3'd5;

    // Events
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_LINE_DONE = 3'd1;
    localparam logic [2:0] EV_FIELD     = 3'd2;
    localparam logic [2:0] EV_COMPLETE  = 3'd3;
    localparam logic [2:0] EV_ERROR     = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_FORMAT   = 3'd1;
    localparam logic [2:0] ERR_METHOD   = 3'd2;
    localparam logic [2:0] ERR_VERSION  = 3'd3;
    localparam logic [2:0] ERR_NO_COLON = 3'd4;
    localparam logic [2:0] ERR_FIELDS   = 3'd5;
    localparam logic [2:0] ERR_LENGTH   = 3'd6;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] UC_MASK  = 8'h5F;

    localparam logic [9:0] SPACES_MAX = 10'd1023;
    localparam logic [3:0] VPREFIX_LEN = 4'd5;

    // Method name character at a position, names packed first char high
    function automatic logic [7:0] meth_char(input logic [2:0] m, input logic [2:0] pos);
        logic [63:0] s;
        case (m)
            3'd0:    s = {"GET ", 32'h0};
            3'd1:    s = {"HEAD ", 24'h0};
            3'd2:    s = {"POST ", 24'h0};
            3'd3:    s = {"PUT ", 32'h0};
            3'd4:    s = {"DELETE ", 8'h0};
            3'd5:    s = "CONNECT ";
            3'd6:    s = "OPTIONS ";
            default: s = {"TRACE ", 16'h0};
        endcase
        meth_char = s[{3'(3'd7 - pos), 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] meth_len(input logic [2:0] m);
        case (m)
            3'd0:    meth_len = 4'd4;
            3'd1:    meth_len = 4'd5;
            3'd2:    meth_len = 4'd5;
            3'd3:    meth_len = 4'd4;
            3'd4:    meth_len = 4'd7;
            3'd5:    meth_len = 4'd8;
            3'd6:    meth_len = 4'd8;
            default: meth_len = 4'd6;
        endcase
    endfunction

    function automatic logic [7:0] ver_char(input logic [2:0] pos);
        logic [39:0] s;
        s = "HTTP/";
        ver_char = s[{3'(3'd4 - pos), 3'b000} +: 8];
    endfunction

endpackage

/* hw/rtl/http_request_header_parser_top.sv */
`timescale 1ns / 1ps
// A result word is registered and shows on the output in the cycle after its byte is taken.
// Throughput: one byte word per cycle; a new word is taken when the result register is empty or
// its word is taken in the same cycle, so a stalled receiver stalls the input after one word.
// Reset: synchronous, active low on i_rst_n; clears the parser to the method phase and drops
// o_valid. A byte with i_start_request high clears the parser state the same way first.
module http_request_header_parser_top #(
    parameter int MAX_FIELDS   = hrhp_pkg::HRHP_MAX_FIELDS,
    parameter int HEADER_BYTES = hrhp_pkg::HRHP_HEADER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_request,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_role,
    output logic [9:0] o_spaces_before,
    output logic [2:0] o_method_code,
    output logic [5:0] o_field_index,
    output logic [2:0] o_event_res,
    output logic [2:0] o_error_code
);
    import hrhp_pkg::*;

    // Field counter reaches MAX_FIELDS, byte counter reaches HEADER_BYTES
    localparam int FCW = $clog2(MAX_FIELDS + 1);
    localparam int BCW = $clog2(HEADER_BYTES + 1);

    // ---------------------------------------------------------------- parser state
    t_phase           r_phase;
    logic [7:0]       r_cand;
    logic [3:0]       r_match_pos;
    logic [2:0]       r_ver_count;
    logic             r_after_dash;
    logic [9:0]       r_pending;
    logic             r_cr_seen;
    logic             r_line_empty;
    logic [FCW-1:0]   r_field_count;
    logic [BCW-1:0]   r_byte_count;
    logic [2:0]       r_err;

    // state as seen by this byte (after an optional start clear)
    t_phase           e_phase;
    logic [7:0]       e_cand;
    logic [3:0]       e_match_pos;
    logic [2:0]       e_ver_count;
    logic             e_after_dash;
    logic [9:0]       e_pending;
    logic             e_cr_seen;
    logic             e_line_empty;
    logic [FCW-1:0]   e_field_count;
    logic [BCW-1:0]   e_byte_count;
    logic [2:0]       e_err;

    t_phase           n_phase;
    logic [7:0]       n_cand;
    logic [3:0]       n_match_pos;
    logic [2:0]       n_ver_count;
    logic             n_after_dash;
    logic [9:0]       n_pending;
    logic             n_cr_seen;
    logic             n_line_empty;
    logic [FCW-1:0]   n_field_count;
    logic [BCW-1:0]   n_byte_count;
    logic [2:0]       n_err;

    // ---------------------------------------------------------------- result register
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [2:0]       r_role;
    logic [9:0]       r_spaces;
    logic [2:0]       r_mcode;
    logic [5:0]       r_fidx;
    logic [2:0]       r_event;
    logic [2:0]       r_err_out;

    logic [7:0]       n_out_byte;
    logic [2:0]       n_role;
    logic [9:0]       n_spaces;
    logic [2:0]       n_mcode;
    logic [5:0]       n_fidx;
    logic [2:0]       n_event;

    logic             accept;
    logic             fail;
    logic [2:0]       fail_code;
    logic [7:0]       keep;
    logic [7:0]       hit;
    logic [8:0]       fc_ext;
    logic [7:0]       b;

    // Take a new byte whenever the result register is empty or being drained.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign b       = i_in_byte;

    always_comb begin
        // start of a request clears everything before the byte is parsed
        if (i_start_request) begin
            e_phase       = PH_METHOD;
            e_cand        = 8'hFF;
            e_match_pos   = '0;
            e_ver_count   = '0;
            e_after_dash  = 1'b1;
            e_pending     = '0;
            e_cr_seen     = 1'b0;
            e_line_empty  = 1'b0;
            e_field_count = '0;
            e_byte_count  = '0;
            e_err         = ERR_NONE;
        end else begin
            e_phase       = r_phase;
            e_cand        = r_cand;
            e_match_pos   = r_match_pos;
            e_ver_count   = r_ver_count;
            e_after_dash  = r_after_dash;
            e_pending     = r_pending;
            e_cr_seen     = r_cr_seen;
            e_line_empty  = r_line_empty;
            e_field_count = r_field_count;
            e_byte_count  = r_byte_count;
            e_err         = r_err;
        end
    end

    // Method compare: one lane per candidate name.
    always_comb begin
        keep = '0;
        hit  = '0;
        for (int m = 0; m < 8; m++) begin
            if (e_cand[m] && (e_match_pos < meth_len(3'(m))) &&
                (meth_char(3'(m), e_match_pos[2:0]) == b)) begin
                keep[m] = 1'b1;
                if (4'(e_match_pos + 4'd1) == meth_len(3'(m))) begin
                    hit[m] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_phase       = e_phase;
        n_cand        = e_cand;
        n_match_pos   = e_match_pos;
        n_ver_count   = e_ver_count;
        n_after_dash  = e_after_dash;
        n_pending     = e_pending;
        n_cr_seen     = e_cr_seen;
        n_line_empty  = e_line_empty;
        n_field_count = e_field_count;
        n_byte_count  = e_byte_count;
        n_err         = e_err;

        fc_ext     = 9'(e_field_count);
        n_out_byte = b;
        n_role     = ROLE_NONE;
        n_spaces   = '0;
        n_event    = EV_NONE;
        n_fidx     = fc_ext[5:0];
        fail       = 1'b0;
        fail_code  = ERR_NONE;

        if (e_phase != PH_ERROR && e_phase != PH_DONE) begin
            if (e_byte_count >= BCW'(HEADER_BYTES)) begin
                fail      = 1'b1;
                fail_code = ERR_LENGTH;
            end else begin
                n_byte_count = BCW'(e_byte_count + 1'b1);
                case (e_phase)
                    PH_METHOD: begin
                        if (keep == '0) begin
                            fail      = 1'b1;
                            fail_code = ERR_METHOD;
                        end else if (hit != '0) begin
                            n_cand      = hit;
                            n_match_pos = '0;
                            n_phase     = PH_URI;
                        end else begin
                            n_cand      = keep;
                            n_match_pos = 4'(e_match_pos + 4'd1);
                            n_role      = ROLE_METHOD;
                        end
                    end
                    PH_URI: begin
                        if (b == CH_SPACE) begin
                            n_match_pos = '0;
                            n_phase     = PH_VPREFIX;
                        end else if (b == CH_CR || b == CH_LF) begin
                            fail      = 1'b1;
                            fail_code = ERR_FORMAT;
                        end else begin
                            n_role = ROLE_URI;
                        end
                    end
                    PH_VPREFIX: begin
                        if (e_match_pos >= VPREFIX_LEN ||
                            ver_char(e_match_pos[2:0]) != b) begin
                            fail      = 1'b1;
                            fail_code = ERR_VERSION;
                        end else begin
                            n_match_pos = 4'(e_match_pos + 4'd1);
                            if (4'(e_match_pos + 4'd1) == VPREFIX_LEN) begin
                                n_ver_count = '0;
                                n_phase     = PH_VDIGITS;
                            end
                        end
                    end
                    PH_VDIGITS: begin
                        n_role      = ROLE_VERSION;
                        n_ver_count = 3'(e_ver_count + 3'd1);
                        if (3'(e_ver_count + 3'd1) >= 3'd3) begin
                            n_phase = PH_VEND;
                        end
                    end
                    PH_VEND: begin
                        if (!e_cr_seen) begin
                            if (b == CH_CR) begin
                                n_cr_seen = 1'b1;
                            end else begin
                                fail      = 1'b1;
                                fail_code = ERR_VERSION;
                            end
                        end else if (b == CH_LF) begin
                            n_event      = EV_LINE_DONE;
                            n_phase      = PH_NAME;
                            n_line_empty = 1'b1;
                            n_after_dash = 1'b1;
                            n_cr_seen    = 1'b0;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_VERSION;
                        end
                    end
                    PH_NAME: begin
                        if (e_cr_seen) begin
                            if (b == CH_LF) begin
                                n_cr_seen = 1'b0;
                                n_event   = EV_COMPLETE;
                                n_phase   = PH_DONE;
                            end else begin
                                fail      = 1'b1;
                                fail_code = ERR_FORMAT;
                            end
                        end else if (b == CH_CR) begin
                            if (e_line_empty) begin
                                n_cr_seen = 1'b1;
                            end else begin
                                fail      = 1'b1;
                                fail_code = ERR_NO_COLON;
                            end
                        end else if (b == CH_LF) begin
                            fail      = 1'b1;
                            fail_code = ERR_FORMAT;
                        end else if (e_line_empty && e_field_count >= FCW'(MAX_FIELDS)) begin
                            fail      = 1'b1;
                            fail_code = ERR_FIELDS;
                        end else begin
                            n_line_empty = 1'b0;
                            if (b == CH_COLON) begin
                                n_pending = '0;
                                n_phase   = PH_VLEAD;
                            end else begin
                                // upper-case a letter at the start or after a dash
                                if (e_after_dash && b >= CH_LC_A && b <= CH_LC_Z) begin
                                    n_out_byte = b & UC_MASK;
                                end
                                n_after_dash = (n_out_byte == CH_DASH);
                                n_role       = ROLE_NAME;
                            end
                        end
                    end
                    PH_VLEAD, PH_VALUE: begin
                        if (e_cr_seen) begin
                            if (b == CH_LF) begin
                                n_event       = EV_FIELD;
                                n_field_count = FCW'(e_field_count + 1'b1);
                                n_phase       = PH_NAME;
                                n_line_empty  = 1'b1;
                                n_after_dash  = 1'b1;
                                n_cr_seen     = 1'b0;
                            end else begin
                                fail      = 1'b1;
                                fail_code = ERR_FORMAT;
                            end
                        end else if (b == CH_CR) begin
                            n_cr_seen = 1'b1;
                        end else if (b == CH_LF) begin
                            fail      = 1'b1;
                            fail_code = ERR_FORMAT;
                        end else if (b == CH_SPACE) begin
                            // defer interior spaces; leading ones are dropped
                            if (e_phase == PH_VALUE && e_pending < SPACES_MAX) begin
                                n_pending = 10'(e_pending + 10'd1);
                            end
                        end else begin
                            n_role    = ROLE_VALUE;
                            n_spaces  = e_pending;
                            n_pending = '0;
                            n_phase   = PH_VALUE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // latch the error and drop method candidates when still matching the method
        if (fail) begin
            if (e_phase == PH_METHOD) begin
                n_cand = '0;
            end
            n_err   = fail_code;
            n_phase = PH_ERROR;
            n_event = EV_ERROR;
        end

        // method code: lowest surviving candidate once past the method
        n_mcode = '0;
        if (n_phase != PH_METHOD && n_cand != '0) begin
            for (int m = 7; m >= 0; m--) begin
                if (n_cand[m]) begin
                    n_mcode = 3'(m);
                end
            end
        end
    end

    // Advance parser state on each taken byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_METHOD;
            r_cand        <= 8'hFF;
            r_match_pos   <= '0;
            r_ver_count   <= '0;
            r_after_dash  <= 1'b1;
            r_pending     <= '0;
            r_cr_seen     <= 1'b0;
            r_line_empty  <= 1'b0;
            r_field_count <= '0;
            r_byte_count  <= '0;
            r_err         <= ERR_NONE;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_cand        <= n_cand;
            r_match_pos   <= n_match_pos;
            r_ver_count   <= n_ver_count;
            r_after_dash  <= n_after_dash;
            r_pending     <= n_pending;
            r_cr_seen     <= n_cr_seen;
            r_line_empty  <= n_line_empty;
            r_field_count <= n_field_count;
            r_byte_count  <= n_byte_count;
            r_err         <= n_err;
        end
    end

    // Output valid: set on a taken byte, drop when the result word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: hold while stalled, load on a taken byte.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_byte <= n_out_byte;
            r_role     <= n_role;
            r_spaces   <= n_spaces;
            r_mcode    <= n_mcode;
            r_fidx     <= n_fidx;
            r_event    <= n_event;
            r_err_out  <= n_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_role          = r_role;
    assign o_spaces_before = r_spaces;
    assign o_method_code   = r_mcode;
    assign o_field_index   = r_fidx;
    assign o_event_res     = r_event;
    assign o_error_code    = r_err_out;

endmodule

/* dv/http_request_header_parser_top_tb.sv */
`timescale 1ns / 1ps

module http_request_header_parser_top_tb;
    import hrhp_pkg::*;

    // One result word of the parser, in port order
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] role;
        logic [9:0] spaces_before;
        logic [2:0] method_code;
        logic [5:0] field_index;
        logic [2:0] event_res;
        logic [2:0] error_code;
    } t_parse_word;

    // Header scoreboard: tracks the parser state byte by byte and holds the
    // result words still owed by the block.
    class t_header_scoreboard;
        t_parse_word expected_q[$];
        int          failures;
        string       verbs[8];
        string       ver_tag;
        t_phase      phase;
        logic [7:0]  cand;
        int          match_pos;
        int          ver_cnt;
        int          pend_sp;
        int          field_cnt;
        int          byte_cnt;
        bit          after_dash;
        bit          cr_seen;
        bit          line_empty;
        logic [2:0]  err_latch;

        function new();
            verbs = '{"GET ", "HEAD ", "POST ", "PUT ", "DELETE ", "CONNECT ", "OPTIONS ",
                      "TRACE "};
            ver_tag = "HTTP/";
            failures = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase = PH_METHOD;
            cand = 8'hFF;
            match_pos = 0;
            ver_cnt = 0;
            after_dash = 1'b1;
            pend_sp = 0;
            cr_seen = 1'b0;
            line_empty = 1'b0;
            field_cnt = 0;
            byte_cnt = 0;
            err_latch = ERR_NONE;
        endfunction

        function logic [2:0] raise_error(logic [2:0] code);
            if (phase == PH_METHOD) cand = '0;
            err_latch = code;
            phase = PH_ERROR;
            return EV_ERROR;
        endfunction

        function void open_line();
            phase = PH_NAME;
            line_empty = 1'b1;
            after_dash = 1'b1;
            cr_seen = 1'b0;
        endfunction

        // Advance the parser by one accepted byte and queue the word it owes
        function void note_byte(logic [7:0] b, logic st);
            t_parse_word w;
            logic [7:0]  keep;
            logic [7:0]  hit;
            int          m;
            if (st) clear_parser();
            w = '0;
            w.out_byte = b;
            w.field_index = 6'(field_cnt);
            if (phase != PH_ERROR && phase != PH_DONE) begin
                if (byte_cnt >= HRHP_HEADER_BYTES) begin
                    w.event_res = raise_error(ERR_LENGTH);
                end else begin
                    byte_cnt++;
                    case (phase)
                        PH_METHOD: begin
                            keep = '0;
                            hit = '0;
                            for (m = 0; m < 8; m++) begin
                                if (cand[m] && match_pos < verbs[m].len()
                                        && verbs[m][match_pos] == b) begin
                                    keep[m] = 1'b1;
                                    if (match_pos + 1 == verbs[m].len()) hit[m] = 1'b1;
                                end
                            end
                            if (keep == '0) begin
                                w.event_res = raise_error(ERR_METHOD);
                            end else if (hit != '0) begin
                                cand = hit;
                                match_pos = 0;
                                phase = PH_URI;
                            end else begin
                                cand = keep;
                                match_pos++;
                                w.role = ROLE_METHOD;
                            end
                        end
                        PH_URI: begin
                            if (b == CH_SPACE) begin
                                match_pos = 0;
                                phase = PH_VPREFIX;
                            end else if (b == CH_CR || b == CH_LF) begin
                                w.event_res = raise_error(ERR_FORMAT);
                            end else begin
                                w.role = ROLE_URI;
                            end
                        end
                        PH_VPREFIX: begin
                            if (match_pos >= ver_tag.len() || ver_tag[match_pos] != b) begin
                                w.event_res = raise_error(ERR_VERSION);
                            end else begin
                                match_pos++;
                                if (match_pos == ver_tag.len()) begin
                                    ver_cnt = 0;
                                    phase = PH_VDIGITS;
                                end
                            end
                        end
                        PH_VDIGITS: begin
                            w.role = ROLE_VERSION;
                            ver_cnt++;
                            if (ver_cnt >= 3) phase = PH_VEND;
                        end
                        PH_VEND: begin
                            if (!cr_seen) begin
                                if (b == CH_CR) cr_seen = 1'b1;
                                else w.event_res = raise_error(ERR_VERSION);
                            end else if (b == CH_LF) begin
                                w.event_res = EV_LINE_DONE;
                                open_line();
                            end else begin
                                w.event_res = raise_error(ERR_VERSION);
                            end
                        end
                        PH_NAME: begin
                            if (cr_seen) begin
                                if (b == CH_LF) begin
                                    cr_seen = 1'b0;
                                    w.event_res = EV_COMPLETE;
                                    phase = PH_DONE;
                                end else begin
                                    w.event_res = raise_error(ERR_FORMAT);
                                end
                            end else if (b == CH_CR) begin
                                if (line_empty) cr_seen = 1'b1;
                                else w.event_res = raise_error(ERR_NO_COLON);
                            end else if (b == CH_LF) begin
                                w.event_res = raise_error(ERR_FORMAT);
                            end else if (line_empty && field_cnt >= HRHP_MAX_FIELDS) begin
                                w.event_res = raise_error(ERR_FIELDS);
                            end else begin
                                line_empty = 1'b0;
                                if (b == CH_COLON) begin
                                    pend_sp = 0;
                                    phase = PH_VLEAD;
                                end else begin
                                    if (after_dash && b >= CH_LC_A && b <= CH_LC_Z)
                                        w.out_byte = b & UC_MASK;
                                    after_dash = (w.out_byte == CH_DASH);
                                    w.role = ROLE_NAME;
                                end
                            end
                        end
                        PH_VLEAD, PH_VALUE: begin
                            if (cr_seen) begin
                                if (b == CH_LF) begin
                                    w.event_res = EV_FIELD;
                                    field_cnt++;
                                    open_line();
                                end else begin
                                    w.event_res = raise_error(ERR_FORMAT);
                                end
                            end else if (b == CH_CR) begin
                                cr_seen = 1'b1;
                            end else if (b == CH_LF) begin
                                w.event_res = raise_error(ERR_FORMAT);
                            end else if (b == CH_SPACE) begin
                                if (phase == PH_VALUE && pend_sp < int'(SPACES_MAX)) pend_sp++;
                            end else begin
                                w.role = ROLE_VALUE;
                                w.spaces_before = 10'(pend_sp);
                                pend_sp = 0;
                                phase = PH_VALUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Report the lowest surviving method once the method is settled
            if (phase != PH_METHOD && cand != '0) begin
                for (m = 7; m >= 0; m--)
                    if (cand[m]) w.method_code = 3'(m);
            end
            w.error_code = err_latch;
            expected_q.push_back(w);
        endfunction

        function string show(t_parse_word w);
            return $sformatf("byte=%02h role=%0d sp=%0d meth=%0d fld=%0d ev=%0d err=%0d",
                             w.out_byte, w.role, w.spaces_before, w.method_code,
                             w.field_index, w.event_res, w.error_code);
        endfunction

        function void check_word(t_parse_word got);
            t_parse_word want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) $display("%0t: unexpected word %s", $time, show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch\n  expected %s\n  actual   %s",
                             $time, show(want), show(got));
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_start_request;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic [2:0] o_role;
    logic [9:0] o_spaces_before;
    logic [2:0] o_method_code;
    logic [5:0] o_field_index;
    logic [2:0] o_event_res;
    logic [2:0] o_error_code;

    t_header_scoreboard sb;
    logic [7:0]       req_bytes[$];   // request under construction
    int               bytes_sent;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               hold_req;       // ask the receiver for a long hold-off

    http_request_header_parser_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_start_request (i_start_request),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_role          (o_role),
        .o_spaces_before (o_spaces_before),
        .o_method_code   (o_method_code),
        .o_field_index   (o_field_index),
        .o_event_res     (o_event_res),
        .o_error_code    (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: drop ready at random, or hold it low for a long stretch on request
    initial begin
        int hold_left;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (hold_left = 200; hold_left > 0; hold_left--) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check every result word taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_word({o_out_byte, o_role, o_spaces_before, o_method_code,
                           o_field_index, o_event_res, o_error_code});
    end

    // Offer one byte word from a falling edge on; return at the falling edge after
    // it is taken so the next word can follow back to back.
    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_start_request <= st;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b, st);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Send the built request; mark its first byte as a new request unless told not
    // to, and now and then restart in the middle where that is allowed.
    task automatic send_request(input bit with_start, input bit may_restart);
        int k;
        for (k = 0; k < req_bytes.size(); k++)
            send_byte(req_bytes[k],
                      (k == 0 && with_start) || (may_restart && $urandom_range(0, 299) == 0));
    endtask

    // Pause the sender until every owed word has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic void push_text(string s);
        int k;
        for (k = 0; k < s.len(); k++) req_bytes.push_back(s[k]);
    endfunction

    // Any byte that does not end a URI
    function automatic logic [7:0] uri_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // Name bytes: lean on lower case and dashes to exercise camel-casing
    function automatic logic [7:0] name_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0, 1: c = 8'($urandom_range(8'h61, 8'h7A));
            2:    c = 8'($urandom_range(8'h41, 8'h5A));
            3:    c = CH_DASH;
            4:    c = 8'($urandom_range(8'h30, 8'h39));
            default: begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_CR || c == CH_LF || c == CH_COLON);
            end
        endcase
        return c;
    endfunction

    // Value bytes: plenty of spaces so interior runs get deferred
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 4) return CH_SPACE;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic void push_field(int name_len, int value_len);
        repeat (name_len) req_bytes.push_back(name_char());
        req_bytes.push_back(CH_COLON);
        repeat ($urandom_range(0, 3)) req_bytes.push_back(CH_SPACE);
        repeat (value_len) req_bytes.push_back(value_char());
        repeat ($urandom_range(0, 2)) req_bytes.push_back(CH_SPACE);
        push_text("\015\012");
    endfunction

    // Well-formed request: method, URI, version, n_fields lines, blank line
    function automatic void build_request(int n_fields, int field_max);
        int m;
        req_bytes.delete();
        m = $urandom_range(0, 7);
        push_text(sb.verbs[m]);
        repeat ($urandom_range(0, 8)) req_bytes.push_back(uri_char());
        push_text(" HTTP/");
        repeat (3) req_bytes.push_back(8'($urandom_range(0, 255)));
        push_text("\015\012");
        repeat (n_fields)
            push_field($urandom_range(0, field_max), $urandom_range(0, field_max));
        push_text("\015\012");
    endfunction

    task automatic send_text(string s);
        req_bytes.delete();
        push_text(s);
        send_request(1'b1, 1'b0);
    endtask

    // One random request: mostly well-formed, some broken, cut short or pure noise
    task automatic random_request();
        int pick;
        int pos;
        int m;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            req_bytes.delete();
            repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 20) begin
            // method that breaks off somewhere inside its name
            req_bytes.delete();
            m = $urandom_range(0, 7);
            pos = $urandom_range(0, sb.verbs[m].len() - 1);
            for (k = 0; k < pos; k++) req_bytes.push_back(sb.verbs[m][k]);
            req_bytes.push_back($urandom_range(0, 1) ? CH_SPACE
                                                     : 8'($urandom_range(8'h41, 8'h5A)));
            repeat ($urandom_range(0, 3)) req_bytes.push_back(uri_char());
        end else begin
            build_request($urandom_range(0, 5), 8);
            pos = $urandom_range(0, req_bytes.size() - 1);
            if (pick < 38) begin
                case ($urandom_range(0, 4))
                    0:       req_bytes[pos] = CH_CR;
                    1:       req_bytes[pos] = CH_LF;
                    2:       req_bytes[pos] = CH_SPACE;
                    3:       req_bytes[pos] = CH_COLON;
                    default: req_bytes[pos] = 8'($urandom_range(0, 255));
                endcase
            end else if (pick < 46) begin
                while (req_bytes.size() > pos + 1) void'(req_bytes.pop_back());
            end else if (pick < 56) begin
                // trailing bytes after the header are ignored
                repeat ($urandom_range(1, 4)) req_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_request($urandom_range(0, 19) != 0, 1'b1);
    endtask

    task automatic run_random(int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) random_request();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = '0;
        i_start_request = 1'b0;
        hold_req = 1'b0;
        bytes_sent = 0;
        send_idle_pct = 11;
        recv_idle_pct = 83;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: camel-casing, empty name, skipped and deferred spaces, ignored tail
        send_text({"GET /a HTTP/1.1\015\012host:  x  y  \015\012content-type:v\015\012",
                   ":\015\012\015\012zz"});
        send_text("OPTIONS\015x");                   // method without its space
        send_text("PUT /\015");                       // CR inside the URI
        send_text("HEAD / HTTQ");                     // broken version prefix
        send_text("TRACE / HTTP/1.1\015x");           // CR not followed by LF on version line
        send_text("POST / HTTP/1.0\015\012ab\015");   // CR inside a name
        send_text("DELETE / HTTP/1.0\015\012x:y\012"); // bare LF in a value
        send_text("CONNECT * HTTP/1.1\015\012\015q"); // CR not followed by LF on empty line
        send_text("\377");                            // no method starts with this byte
        run_random(60);
        wait_drained();

        send_idle_pct = 83;
        recv_idle_pct = 11;
        run_random(60);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Field limit: the maximum number of fields is taken, one more line is refused.
        // Hold off the receiver meanwhile so the block backs up into its input.
        hold_req = 1'b1;
        build_request(HRHP_MAX_FIELDS, 0);
        void'(req_bytes.pop_back());
        void'(req_bytes.pop_back());
        req_bytes.push_back(name_char());
        req_bytes.push_back("z");
        send_request(1'b1, 1'b0);
        wait_drained();
        // Long interior space run, then run past the byte budget
        build_request(0, 0);
        void'(req_bytes.pop_back());
        void'(req_bytes.pop_back());
        push_text("long-val:a");
        repeat (600) req_bytes.push_back(CH_SPACE);
        req_bytes.push_back("b");
        while (req_bytes.size() < HRHP_HEADER_BYTES + 6) req_bytes.push_back("c");
        send_request(1'b1, 1'b0);
        wait_drained();
        run_random(60);
        wait_drained();

        // Let any late word show up before judging
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_q.size() == 0) begin
            $display("** http_request_header_parser_top: PASSED **");
        end else begin
            $display("** http_request_header_parser_top: FAILED **");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2000000;
        $display("** http_request_header_parser_top: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hrhp_pkg.sv
hw/rtl/http_request_header_parser_top.sv
dv/http_request_header_parser_top_tb.sv
